// ===== rtl/plob_pkg.sv =====
// Shared types and constants for the price level order book.
`timescale 1ns / 1ps
package plob_pkg;

  localparam int unsigned LEVELS_DEF = 64;
  localparam int unsigned PW = 63;
  localparam int unsigned QW = 64;

  typedef enum logic [1:0] {
    OP_DELTA = 2'd0,
    OP_SNAP_START = 2'd1,
    OP_SNAP_LEVEL = 2'd2,
    OP_RESET = 2'd3
  } opcode_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input request
    logic scan_init; // restart scan pointer and accumulators
    logic scan_step; // evaluate one slot per side
    logic apply;     // perform update at found/free slot
    logic out_load;  // capture result into output register
  } plob_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last; // current slot is the last one
    logic do_update; // request needs a table update
  } plob_sts_t;

endpackage

// ===== rtl/plob_ctrl.sv =====
// Controller state machine for the price level order book.
`timescale 1ns / 1ps
module plob_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  plob_pkg::plob_sts_t sts,
  output plob_pkg::plob_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FIND  = 5'b00010,
    ST_APPLY = 5'b00100,
    ST_BEST  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // Output register frees the pipe: a new request may start while a result waits,
  // but the result of the next request can only land once the old one is gone.
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_init = 1'b1;
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        // One pass over the side to find a match or the first free slot.
        if (!sts.do_update) begin
          cmd.scan_init = 1'b1;
          state_nxt = ST_BEST;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = ST_APPLY;
          end
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt = ST_BEST;
      end
      ST_BEST: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/plob_dp.sv =====
// Datapath: level tables, slot scan, best price search and result register.
`timescale 1ns / 1ps
module plob_dp #(
  parameter int unsigned LEVELS = plob_pkg::LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  plob_pkg::plob_cmd_t        cmd,
  output plob_pkg::plob_sts_t        sts,
  input  logic [1:0]                 in_opcode,
  input  logic                       in_is_ask,
  input  logic [plob_pkg::PW-1:0]    in_price_e8,
  input  logic signed [plob_pkg::QW-1:0] in_qty_e8,
  input  logic [plob_pkg::PW-1:0]    in_stamp_ns,
  output logic [plob_pkg::PW-1:0]    out_best_bid_price,
  output logic [plob_pkg::PW-1:0]    out_best_bid_qty,
  output logic [plob_pkg::PW-1:0]    out_best_ask_price,
  output logic [plob_pkg::PW-1:0]    out_best_ask_qty,
  output logic [plob_pkg::PW-1:0]    out_last_stamp,
  output logic                       out_status
);

  localparam int unsigned AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned PW = plob_pkg::PW;
  localparam int unsigned QW = plob_pkg::QW;

  // Tables as memories: one read port (scan pointer), one write port.
  logic [PW-1:0] bid_price_mem [LEVELS];
  logic [QW-1:0] bid_qty_mem   [LEVELS];
  logic [PW-1:0] ask_price_mem [LEVELS];
  logic [QW-1:0] ask_qty_mem   [LEVELS];
  logic [LEVELS-1:0] bid_valid_r, ask_valid_r;

  // Captured request.
  logic [1:0]    op_r;
  logic          ask_r;
  logic [PW-1:0] price_r;
  logic [QW-1:0] qty_r;
  logic [PW-1:0] ts_r, ts_nxt;

  // Scan state: address issued, read data registered in the next cycle.
  logic [AW-1:0] addr_r;
  logic [AW:0]   cnt_r;      // slots evaluated so far
  logic          rd_vld_r;
  logic [AW-1:0] rd_addr_r;
  logic [PW-1:0] bp_rd_r, ap_rd_r;
  logic [QW-1:0] bq_rd_r, aq_rd_r;

  logic          hit_r, free_ok_r;
  logic [AW-1:0] hit_idx_r, free_idx_r;
  logic          drop_r;

  logic          bb_found_r, ba_found_r, az_found_r;
  logic [PW-1:0] bb_p_r, ba_p_r;
  logic [QW-1:0] bb_q_r, ba_q_r, az_q_r;

  logic qty_pos, qty_zero, do_update;
  assign qty_zero = (qty_r == '0);
  assign qty_pos  = !qty_zero && !qty_r[QW-1];
  assign do_update = (op_r == plob_pkg::OP_DELTA) ||
                     ((op_r == plob_pkg::OP_SNAP_LEVEL) && qty_pos);

  assign sts.do_update = do_update;
  assign sts.scan_last = rd_vld_r && (cnt_r == (AW+1)'(LEVELS - 1));

  // Memory reads, address from the scan pointer.
  always_ff @(posedge clk) begin
    bp_rd_r <= bid_price_mem[addr_r];
    bq_rd_r <= bid_qty_mem[addr_r];
    ap_rd_r <= ask_price_mem[addr_r];
    aq_rd_r <= ask_qty_mem[addr_r];
  end

  // Memory writes on apply.
  logic          wr_en;
  logic [AW-1:0] wr_idx;
  assign wr_en  = cmd.apply && !qty_zero && (hit_r || free_ok_r);
  assign wr_idx = hit_r ? hit_idx_r : free_idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (ask_r) begin
        ask_price_mem[wr_idx] <= price_r;
        ask_qty_mem[wr_idx] <= qty_r;
      end else begin
        bid_price_mem[wr_idx] <= price_r;
        bid_qty_mem[wr_idx] <= qty_r;
      end
    end
  end

  // Current slot seen by the scan.
  logic s_bv, s_av, s_sv, s_match;
  logic [PW-1:0] s_price;
  assign s_bv = bid_valid_r[rd_addr_r];
  assign s_av = ask_valid_r[rd_addr_r];
  assign s_sv = ask_r ? s_av : s_bv;
  assign s_price = ask_r ? ap_rd_r : bp_rd_r;
  assign s_match = s_sv && (s_price == price_r);

  logic bq_pos, aq_pos;
  assign bq_pos = (bq_rd_r != '0) && !bq_rd_r[QW-1];
  assign aq_pos = (aq_rd_r != '0) && !aq_rd_r[QW-1];

  assign ts_nxt = (op_r == plob_pkg::OP_RESET) ? '0 : ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bid_valid_r <= '0;
      ask_valid_r <= '0;
      ts_r <= '0;
      addr_r <= '0;
      cnt_r <= '0;
      rd_vld_r <= 1'b0;
      out_status <= 1'b0;
      out_last_stamp <= '0;
      out_best_bid_price <= '0;
      out_best_bid_qty <= '0;
      out_best_ask_price <= '0;
      out_best_ask_qty <= '0;
    end else begin
      if (cmd.load) begin
        op_r <= in_opcode;
        ask_r <= in_is_ask;
        price_r <= in_price_e8;
        qty_r <= in_qty_e8;
        ts_r <= (in_opcode == plob_pkg::OP_RESET) ? '0 : in_stamp_ns;
        drop_r <= 1'b0;
        if (in_opcode == plob_pkg::OP_SNAP_START || in_opcode == plob_pkg::OP_RESET) begin
          bid_valid_r <= '0;
          ask_valid_r <= '0;
        end
      end
      if (cmd.scan_init) begin
        addr_r <= '0;
        cnt_r <= '0;
        rd_vld_r <= 1'b0;
        hit_r <= 1'b0;
        free_ok_r <= 1'b0;
        bb_found_r <= 1'b0;
        ba_found_r <= 1'b0;
        az_found_r <= 1'b0;
        bb_p_r <= '0;
        bb_q_r <= '0;
        ba_p_r <= '0;
        ba_q_r <= '0;
        az_q_r <= '0;
      end else if (cmd.scan_step) begin
        if (addr_r != AW'(LEVELS - 1)) begin
          addr_r <= addr_r + 1'b1;
        end
        rd_vld_r <= 1'b1;
        if (rd_vld_r) begin
          cnt_r <= cnt_r + 1'b1;
          rd_addr_r <= rd_addr_r + 1'b1;
          // match / free slot search
          if (s_match && !hit_r) begin
            hit_r <= 1'b1;
            hit_idx_r <= rd_addr_r;
          end
          if (!s_sv && !free_ok_r) begin
            free_ok_r <= 1'b1;
            free_idx_r <= rd_addr_r;
          end
          // best bid
          if (s_bv && bq_pos && (bp_rd_r > bb_p_r)) begin
            bb_p_r <= bp_rd_r;
            bb_q_r <= bq_rd_r;
          end
          // best ask, price zero kept apart
          if (s_av && aq_pos) begin
            if (ap_rd_r == '0) begin
              az_found_r <= 1'b1;
              az_q_r <= aq_rd_r;
            end else if (!ba_found_r || (ap_rd_r < ba_p_r)) begin
              ba_found_r <= 1'b1;
              ba_p_r <= ap_rd_r;
              ba_q_r <= aq_rd_r;
            end
          end
        end else begin
          rd_addr_r <= '0;
        end
      end
      if (cmd.apply) begin
        if (hit_r && qty_zero) begin
          if (ask_r) ask_valid_r[hit_idx_r] <= 1'b0;
          else bid_valid_r[hit_idx_r] <= 1'b0;
        end else if (!hit_r && !qty_zero) begin
          if (free_ok_r) begin
            if (ask_r) ask_valid_r[free_idx_r] <= 1'b1;
            else bid_valid_r[free_idx_r] <= 1'b1;
          end else begin
            drop_r <= 1'b1;
          end
        end
      end
      if (cmd.out_load) begin
        out_best_bid_price <= bb_p_r;
        out_best_bid_qty <= bb_q_r[PW-1:0];
        out_best_ask_price <= ba_found_r ? ba_p_r : '0;
        out_best_ask_qty <= ba_found_r ? ba_q_r[PW-1:0] :
                            (az_found_r ? az_q_r[PW-1:0] : '0);
        out_last_stamp <= ts_nxt;
        out_status <= drop_r;
      end
    end
  end

endmodule

// ===== rtl/price_level_order_book.sv =====
// Top level of the price level order book.
`timescale 1ns / 1ps
//
//  channel  direction  handshake               payload
//  in_      input      in_valid / in_ready     opcode, is_ask, price_e8, qty_e8, stamp_ns
//  out_     output     out_valid / out_ready   best bid/ask price and qty, last_stamp, status
//
// A request that updates a side takes one pass through the level memory to find a
// match or free slot and one pass for the best prices; any other request takes only
// the best price pass. The single read port of the level memories sets this.
// in_ready returns with the result. Reset (rst_n low, synchronous) clears all valid
// bits at once. A result waits in the output register; the next request may be
// accepted meanwhile.
module price_level_order_book #(
  parameter int unsigned LEVELS = plob_pkg::LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_opcode,
  input  logic                           in_is_ask,
  input  logic [plob_pkg::PW-1:0]        in_price_e8,
  input  logic signed [plob_pkg::QW-1:0] in_qty_e8,
  input  logic [plob_pkg::PW-1:0]        in_stamp_ns,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [plob_pkg::PW-1:0]        out_best_bid_price,
  output logic [plob_pkg::PW-1:0]        out_best_bid_qty,
  output logic [plob_pkg::PW-1:0]        out_best_ask_price,
  output logic [plob_pkg::PW-1:0]        out_best_ask_qty,
  output logic [plob_pkg::PW-1:0]        out_last_stamp,
  output logic                           out_status
);

  plob_pkg::plob_cmd_t cmd;
  plob_pkg::plob_sts_t sts;

  plob_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );

  plob_dp #(.LEVELS(LEVELS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_opcode(in_opcode), .in_is_ask(in_is_ask), .in_price_e8(in_price_e8),
    .in_qty_e8(in_qty_e8), .in_stamp_ns(in_stamp_ns),
    .out_best_bid_price(out_best_bid_price), .out_best_bid_qty(out_best_bid_qty),
    .out_best_ask_price(out_best_ask_price), .out_best_ask_qty(out_best_ask_qty),
    .out_last_stamp(out_last_stamp), .out_status(out_status)
  );

`ifndef SYNTH
  // A result is only loaded when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && out_valid) |-> out_ready)
    else $error("result overwritten");

  // Table is only updated outside the idle state.
  a_apply_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> !in_ready)
    else $error("update while idle");

  // A stalled result stays put until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_best_bid_price) &&
                                   $stable(out_best_ask_price) && $stable(out_status)))
    else $error("result changed while stalled");
`endif

endmodule

// ===== tb/price_level_order_book_tb.sv =====
// Self-checking testbench for the price level order book.
`timescale 1ns / 1ps
module price_level_order_book_tb;

  localparam int NLEV = 64;
  localparam int CYC_LIMIT = 2000000;
  localparam int PW = plob_pkg::PW;
  localparam int QW = plob_pkg::QW;

  typedef struct packed {
    logic [PW-1:0] bid_p;
    logic [PW-1:0] bid_q;
    logic [PW-1:0] ask_p;
    logic [PW-1:0] ask_q;
    logic [PW-1:0] stamp;
    logic          status;
  } quote_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic in_is_ask = 0;
  logic [PW-1:0] in_price_e8 = '0;
  logic signed [QW-1:0] in_qty_e8 = '0;
  logic [PW-1:0] in_stamp_ns = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [PW-1:0] out_best_bid_price, out_best_bid_qty;
  logic [PW-1:0] out_best_ask_price, out_best_ask_qty, out_last_stamp;
  logic out_status;

  price_level_order_book dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Book mirror.
  logic [PW-1:0] bk_price [2][NLEV];
  logic [QW-1:0] bk_qty [2][NLEV];
  bit bk_valid [2][NLEV];
  logic [PW-1:0] bk_stamp;

  quote_t quote_q [$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;

  task automatic report(string what, logic [PW-1:0] got, logic [PW-1:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  function automatic bit positive(logic [QW-1:0] q);
    return q != 0 && !q[QW-1];
  endfunction

  function automatic void clear_book();
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < NLEV; i++) bk_valid[s][i] = 0;
  endfunction

  function automatic bit place_level(int s, logic [PW-1:0] p, logic [QW-1:0] q);
    int fr;
    fr = -1;
    for (int i = 0; i < NLEV; i++) begin
      if (bk_valid[s][i] && bk_price[s][i] == p) begin
        if (q == 0) bk_valid[s][i] = 0;
        else bk_qty[s][i] = q;
        return 0;
      end
      if (!bk_valid[s][i] && fr < 0) fr = i;
    end
    if (q == 0) return 0;
    if (fr < 0) return 1;
    bk_price[s][fr] = p;
    bk_qty[s][fr] = q;
    bk_valid[s][fr] = 1;
    return 0;
  endfunction

  function automatic quote_t predict_quote(logic [1:0] op, logic ask, logic [PW-1:0] p,
                                           logic [QW-1:0] q, logic [PW-1:0] st);
    quote_t r;
    bit found, zfound;
    logic [PW-1:0] zq;
    r = '0;
    found = 0;
    zfound = 0;
    zq = '0;
    if (op == plob_pkg::OP_DELTA || op == plob_pkg::OP_SNAP_LEVEL) begin
      if (op == plob_pkg::OP_DELTA || positive(q)) r.status = place_level(ask, p, q);
      bk_stamp = st;
    end else if (op == plob_pkg::OP_SNAP_START) begin
      clear_book();
      bk_stamp = st;
    end else begin
      clear_book();
      bk_stamp = '0;
    end
    for (int i = 0; i < NLEV; i++) begin
      if (bk_valid[0][i] && positive(bk_qty[0][i]) && bk_price[0][i] > r.bid_p) begin
        r.bid_p = bk_price[0][i];
        r.bid_q = bk_qty[0][i][PW-1:0];
      end
      if (bk_valid[1][i] && positive(bk_qty[1][i])) begin
        if (bk_price[1][i] == 0) begin
          zfound = 1;
          zq = bk_qty[1][i][PW-1:0];
        end else if (!found || bk_price[1][i] < r.ask_p) begin
          found = 1;
          r.ask_p = bk_price[1][i];
          r.ask_q = bk_qty[1][i][PW-1:0];
        end
      end
    end
    if (!found && zfound) r.ask_q = zq;
    r.stamp = bk_stamp;
    return r;
  endfunction

  // Valid stays up after acceptance until the next request or an idle cycle replaces it.
  task automatic send_level(logic [1:0] op, logic ask, logic [PW-1:0] p,
                            logic [QW-1:0] q, logic [PW-1:0] st);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_is_ask <= ask;
    in_price_e8 <= p;
    in_qty_e8 <= q;
    in_stamp_ns <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    quote_q.insert(quote_q.size(), predict_quote(op, ask, p, q, st));
  endtask

  function automatic logic [PW-1:0] rnd63();
    return PW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [QW-1:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (quote_q.size() != 0) @(posedge clk);
  endtask

  // Receiver.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (quote_q.size() == 0) begin
          report("unexpected result", '0, '0);
        end else begin
          quote_t e;
          e = quote_q.pop_front();
          if (out_best_bid_price !== e.bid_p) report("bid price", out_best_bid_price, e.bid_p);
          if (out_best_bid_qty !== e.bid_q) report("bid qty", out_best_bid_qty, e.bid_q);
          if (out_best_ask_price !== e.ask_p) report("ask price", out_best_ask_price, e.ask_p);
          if (out_best_ask_qty !== e.ask_q) report("ask qty", out_best_ask_qty, e.ask_q);
          if (out_last_stamp !== e.stamp) report("stamp", out_last_stamp, e.stamp);
          if (out_status !== e.status) report("status", out_status, e.status);
        end
      end
      out_ready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic test_directed();
    send_level(plob_pkg::OP_DELTA, 0, '1, 64'sh7FFF_FFFF_FFFF_FFFF, '1);
    send_level(plob_pkg::OP_DELTA, 1, '1, 64'sd5, 63'd1);
    send_level(plob_pkg::OP_DELTA, 1, '0, 64'sd9, 63'd2);   // zero ask hidden by nonzero ask
    send_level(plob_pkg::OP_DELTA, 1, '1, 64'sd0, 63'd3);   // delete exposes zero-price ask
    send_level(plob_pkg::OP_DELTA, 0, '0, 64'sd7, 63'd4);   // zero bid never best
    send_level(plob_pkg::OP_DELTA, 0, 63'd10, -64'sd1, 63'd5); // negative qty kept, not best
    send_level(plob_pkg::OP_DELTA, 0, 63'd11, 64'sh8000_0000_0000_0000, 63'd6);
    send_level(plob_pkg::OP_DELTA, 0, 63'd99, 64'sd0, 63'd7);  // delete of missing price
    send_level(plob_pkg::OP_SNAP_LEVEL, 0, 63'd20, 64'sd0, 63'd8); // skipped snapshot levels
    send_level(plob_pkg::OP_SNAP_LEVEL, 1, 63'd20, -64'sd4, 63'd9);
    send_level(plob_pkg::OP_SNAP_LEVEL, 0, 63'd20, 64'sd3, 63'd10);
    send_level(plob_pkg::OP_SNAP_START, 1, '1, '1, '1);
    send_level(plob_pkg::OP_DELTA, 0, 63'd3, 64'sd3, 63'd11);
    send_level(plob_pkg::OP_RESET, 1, '1, '1, '1);
    // fill the bid side, then overflow and overwrite
    for (int i = 1; i <= NLEV; i++)
      send_level(plob_pkg::OP_DELTA, 0, PW'(i), QW'(i), PW'(i));
    send_level(plob_pkg::OP_DELTA, 0, 63'd1000, 64'sd1, 63'd100);
    send_level(plob_pkg::OP_DELTA, 0, 63'd5, 64'sd77, 63'd101);
    send_level(plob_pkg::OP_SNAP_LEVEL, 0, 63'd1001, 64'sd1, 63'd102);
    send_level(plob_pkg::OP_RESET, 0, '0, '0, '0);
    drain();
  endtask

  // Random traffic: mostly small price ranges so levels collide and sides fill.
  task automatic test_random(int n, int idle, int stall);
    logic [1:0] op;
    logic [PW-1:0] p;
    logic [QW-1:0] q;
    int k;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(199);
      op = k < 2 ? plob_pkg::OP_RESET : k < 6 ? plob_pkg::OP_SNAP_START :
           k < 60 ? plob_pkg::OP_SNAP_LEVEL : plob_pkg::OP_DELTA;
      p = $urandom_range(9) == 0 ? rnd63() : 63'($urandom_range(90));
      case ($urandom_range(9))
        0, 1: q = '0;
        2: q = rnd64();
        3: q = -64'($urandom_range(50));
        default: q = 64'($urandom_range(1000, 1));
      endcase
      send_level(op, 1'($urandom_range(1)), p, q, rnd63());
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1;
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 10; i++)
        send_level(plob_pkg::OP_DELTA, 1'(i % 2), PW'(i + 1), QW'(i + 1), PW'(i));
    join
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(400, 0, 0);
    test_random(350, 71, 0);
    test_random(350, 0, 71);
    test_random(350, 31, 31);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/plob_pkg.sv
rtl/plob_ctrl.sv
rtl/plob_dp.sv
rtl/price_level_order_book.sv
tb/price_level_order_book_tb.sv
